// ===== rtl/core/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Entry layout, operation and status codes, table sizing.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // operation codes
   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_LOOKUP    = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_REMOVE    = 3'd3;
   localparam logic [2:0] OP_OLDER     = 3'd4;
   localparam logic [2:0] OP_SMALLEST  = 3'd5;

   // status codes
   localparam logic [2:0] ST_APPENDED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_EVICTED   = 3'd2;
   localparam logic [2:0] ST_HIT       = 3'd3;
   localparam logic [2:0] ST_MISS      = 3'd4;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] recnum;
      logic [31:0] arrival;
   } entry_type;

   // per cell control from the sequencer
   typedef struct packed {
      logic wr;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== rtl/core/krt_if.sv =====
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if: request and result channels
// Valid/ready channels carrying the table request and its result.
// ----------------------------------------------------------------------------
interface krt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] entry_id;
   logic [31:0] record_number;
   logic [31:0] arrival_time;
   logic [3:0]  slot_index;
   logic [31:0] cutoff_time;

   modport source (output valid, operation, entry_id, record_number, arrival_time,
                   slot_index, cutoff_time, input ready);
   modport sink   (input valid, operation, entry_id, record_number, arrival_time,
                   slot_index, cutoff_time, output ready);
endinterface

interface krt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] out_id;
   logic [31:0] out_record_number;
   logic [31:0] out_arrival_time;
   logic [4:0]  removed_count;
   logic [4:0]  occupancy;

   modport source (output valid, status, out_id, out_record_number, out_arrival_time,
                   removed_count, occupancy, input ready);
   modport sink   (input valid, status, out_id, out_record_number, out_arrival_time,
                   removed_count, occupancy, output ready);
endinterface

// ===== rtl/core/krt_cell.sv =====
// ----------------------------------------------------------------------------
// krt_cell: one table slot
// Holds one record; loads new data or takes its upper neighbour's record.
// ----------------------------------------------------------------------------
module krt_cell (
   input  logic                  clock,
   input  krt_pkg::cell_ctl_type ctl,
   input  krt_pkg::entry_type    wr_data,
   input  krt_pkg::entry_type    nbr_data,
   output krt_pkg::entry_type    data
);
   import krt_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   // write wins, else close the gap from the neighbour
   always_comb begin
      priority if (ctl.wr) begin
         data_in = wr_data;
      end else if (ctl.shift) begin
         data_in = nbr_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/core/keyed_record_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_core: keyed record table with smallest eviction
// Row of slot cells plus a sequencer that walks them in insertion order.
// ----------------------------------------------------------------------------
// Usage: a request on req_bus carries an operation and its operands; one
// result per request comes back on rsp_bus. csr_wr_en/csr_wr_data set the
// number of slots in use and must only be written while the block is idle.
// The sequencer walks the slots one per cycle, while the result register is
// free or being taken, through a single read port on the cell row; removal
// closes the gap by shifting the row, every cell at or above the removed slot
// taking its upper neighbour's record. An add to a full table that finds no
// matching id walks twice, the second walk finding the smallest record number
// to evict. One request is in flight at a time.
// The result waits in an output register; a new request is taken as soon as
// the walk ends, and a walk that finishes while the result is still held
// stalls until the receiver takes it.
// Reset empties the table and sets the slots in use to the full capacity;
// stored records are not cleared.
// ----------------------------------------------------------------------------
module keyed_record_table_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   krt_req_if.sink    req_bus,
   krt_rsp_if.source  rsp_bus
);
   import krt_pkg::*;

   localparam logic [1:0] SQ_IDLE  = 2'd0;
   localparam logic [1:0] SQ_SCAN  = 2'd1;
   localparam logic [1:0] SQ_SMALL = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [4:0]       cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] rc_ff, rc_in;
   logic [IDX_W-1:0] best_pos_ff, best_pos_in;
   entry_type        best_ff, best_in;

   // latched request
   logic [2:0]       op_ff;
   logic [15:0]      id_ff;
   logic [31:0]      rn_ff, at_ff, cut_ff;
   logic [3:0]       slot_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   entry_type        rsp_entry_ff;
   logic [4:0]       rsp_rc_ff, rsp_occ_ff;

   entry_type        cell_q [CAPACITY];
   cell_ctl_type     cell_ctl [CAPACITY];
   entry_type        wr_data, cur;
   logic             wr_en, shift_en, fin, go, in_range, accept;
   logic [IDX_W-1:0] pos;
   logic [2:0]       res_status;
   entry_type        res_entry;
   logic [CNT_W-1:0] res_rc;
   logic [CNT_W-1:0] eff_cap;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == SQ_IDLE);
   assign go            = !rsp_valid_ff || rsp_bus.ready;
   assign cur           = cell_q[ptr_ff[IDX_W-1:0]];
   assign in_range      = ptr_ff < count_ff;
   assign wr_data       = '{id: id_ff, recnum: rn_ff, arrival: at_ff};

   // effective slots in use, clamped to 1..CAPACITY
   always_comb begin
      priority if (cap_ff == 5'd0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > CAPACITY) begin
         eff_cap = CNT_W'(CAPACITY);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type nbr;
      if (g == CAPACITY - 1) begin : g_top
         assign nbr = cell_q[g];
      end else begin : g_mid
         assign nbr = cell_q[g+1];
      end
      assign cell_ctl[g].wr    = wr_en && (pos == IDX_W'(g));
      assign cell_ctl[g].shift = shift_en && (pos <= IDX_W'(g));
      krt_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[g]),
         .wr_data  (wr_data),
         .nbr_data (nbr),
         .data     (cell_q[g])
      );
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      rc_in       = rc_ff;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      wr_en       = 1'b0;
      shift_en    = 1'b0;
      pos         = ptr_ff[IDX_W-1:0];
      fin         = 1'b0;
      res_status  = ST_MISS;
      res_entry   = '0;
      res_rc      = '0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               rc_in    = '0;
               ptr_in   = (req_bus.operation == OP_READ) ? CNT_W'(req_bus.slot_index) : '0;
               state_in = (req_bus.operation == OP_SMALLEST) ? SQ_SMALL : SQ_SCAN;
            end
         end
         SQ_SCAN: begin
            if (go) begin
               unique case (op_ff)
                  OP_ADD, OP_LOOKUP, OP_REMOVE: begin
                     if (!in_range) begin
                        if (op_ff != OP_ADD) begin
                           fin = 1'b1;
                        end else if (count_ff < eff_cap) begin
                           wr_en      = 1'b1;
                           pos        = count_ff[IDX_W-1:0];
                           count_in   = count_ff + 1'b1;
                           res_status = ST_APPENDED;
                           fin        = 1'b1;
                        end else begin
                           ptr_in   = '0;
                           state_in = SQ_SMALL;
                        end
                     end else if (cur.id == id_ff) begin
                        fin = 1'b1;
                        if (op_ff == OP_ADD) begin
                           wr_en      = 1'b1;
                           res_status = ST_UPDATED;
                        end else begin
                           res_status = ST_HIT;
                           res_entry  = cur;
                           if (op_ff == OP_REMOVE) begin
                              shift_en = 1'b1;
                              count_in = count_ff - 1'b1;
                           end
                        end
                     end else begin
                        ptr_in = ptr_ff + 1'b1;
                     end
                  end
                  OP_READ: begin
                     fin = 1'b1;
                     if (in_range) begin
                        res_status = ST_HIT;
                        res_entry  = cur;
                     end
                  end
                  OP_OLDER: begin
                     if (!in_range) begin
                        fin        = 1'b1;
                        res_rc     = rc_ff;
                        res_status = (rc_ff != '0) ? ST_HIT : ST_MISS;
                     end else if (cur.arrival < cut_ff) begin
                        shift_en = 1'b1;
                        count_in = count_ff - 1'b1;
                        rc_in    = rc_ff + 1'b1;
                     end else begin
                        ptr_in = ptr_ff + 1'b1;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         SQ_SMALL: begin
            if (go) begin
               if (in_range) begin
                  if (ptr_ff == '0 || cur.recnum < best_ff.recnum) begin
                     best_in     = cur;
                     best_pos_in = ptr_ff[IDX_W-1:0];
                  end
                  ptr_in = ptr_ff + 1'b1;
               end else begin
                  fin = 1'b1;
                  pos = best_pos_ff;
                  if (op_ff == OP_ADD) begin
                     wr_en      = 1'b1;
                     res_status = ST_EVICTED;
                  end else if (count_ff != '0) begin
                     shift_en   = 1'b1;
                     count_in   = count_ff - 1'b1;
                     res_status = ST_HIT;
                     res_entry  = best_ff;
                  end
               end
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
      if (fin) begin
         state_in = SQ_IDLE;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         count_ff     <= '0;
         cap_ff       <= 5'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk registers and request operands
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      rc_ff       <= rc_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      if (accept) begin
         op_ff   <= req_bus.operation;
         id_ff   <= req_bus.entry_id;
         rn_ff   <= req_bus.record_number;
         at_ff   <= req_bus.arrival_time;
         slot_ff <= req_bus.slot_index;
         cut_ff  <= req_bus.cutoff_time;
      end
      if (fin) begin
         rsp_status_ff <= res_status;
         rsp_entry_ff  <= res_entry;
         rsp_rc_ff     <= 5'(res_rc);
         rsp_occ_ff    <= 5'(count_in);
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_status_ff;
   assign rsp_bus.out_id            = rsp_entry_ff.id;
   assign rsp_bus.out_record_number = rsp_entry_ff.recnum;
   assign rsp_bus.out_arrival_time  = rsp_entry_ff.arrival;
   assign rsp_bus.removed_count     = rsp_rc_ff;
   assign rsp_bus.occupancy         = rsp_occ_ff;

   // read slot request keeps its slot in the walk pointer
   a_read_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_SCAN && op_ff == OP_READ |-> ptr_ff == CNT_W'(slot_ff))
      else $error("read slot pointer lost");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_occ_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_occ_ff == 5'(count_ff))
      else $error("reported occupancy differs from entry count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != SQ_IDLE)
      else $error("accepted request did not start a walk");

endmodule
